// ----- sv/tlsd_pkg.sv -----
// Shared types, constants and character tables for the type/length string decoder.
package tlsd_pkg;

    // Depth of the result queue; it must hold the two results of one byte.
    localparam int RESULT_DEPTH = 4;

    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 6;
    localparam int CAP_W   = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TYPE3_UNICODE = 2'd0,
        CFG_FRU_SEMANTICS = 2'd1,
        CFG_OUT_CAPACITY  = 2'd2
    } t_cfg_index;

    // Field encodings, as carried in bits 7:6 of a header.
    typedef enum logic [1:0] {
        ENC_RAW   = 2'd0,
        ENC_BCD   = 2'd1,
        ENC_SIX   = 2'd2,
        ENC_ASCII = 2'd3
    } t_enc;

    typedef enum logic [1:0] {
        KIND_ASCII   = 2'd0,
        KIND_UNICODE = 2'd1,
        KIND_BINARY  = 2'd2
    } t_kind;

    typedef struct packed {
        logic             type3_unicode;
        logic             fru_semantics;
        logic [CAP_W-1:0] out_capacity;
    } t_cfg;

    typedef struct packed {
        logic              decode_error;
        t_kind             string_kind;
        logic              last_of_string;
        logic              char_valid;
        logic [CHAR_W-1:0] char_out;
    } t_result;

    // BCD-plus code to character.
    function automatic logic [CHAR_W-1:0] bcd_char(input logic [3:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            4'hA:    ch = 8'h20;  // space
            4'hB:    ch = 8'h2D;  // dash
            4'hC:    ch = 8'h2E;  // period
            4'hD:    ch = 8'h3A;  // colon
            4'hE:    ch = 8'h2C;  // comma
            4'hF:    ch = 8'h5F;  // underscore
            default: ch = 8'h30 + {4'h0, code};
        endcase
        return ch;
    endfunction

endpackage

// ----- sv/tlsd_decode.sv -----
// Header check and per-byte character decode, with the field state registers.
module tlsd_decode
    import tlsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [CHAR_W-1:0] i_byte,
    input  logic              i_hdr,
    input  logic [7:0]        i_avail,
    input  t_cfg              i_cfg,
    output t_result           o_res0,
    output t_result           o_res1,
    output logic [1:0]        o_count
);

    logic               r_in_field, n_in_field;
    t_enc               r_enc, n_enc;
    logic [COUNT_W-1:0] r_left, n_left;
    logic [2:0]         r_off, n_off;
    logic [5:0]         r_carry, n_carry;
    t_kind              r_kind, n_kind;

    always_comb begin
        logic [1:0]   typ;
        logic [5:0]   len;
        logic         too_big;
        logic [2:0]   n0;
        logic [5:0]   mask;
        logic [13:0]  acc;
        logic         want2;
        logic         end0;
        logic         end1;
        logic [7:0]   c0;
        logic [7:0]   c1;
        t_kind        kind;

        n_in_field = r_in_field;
        n_enc      = r_enc;
        n_left     = r_left;
        n_off      = r_off;
        n_carry    = r_carry;
        n_kind     = r_kind;
        o_res0     = '0;
        o_res1     = '0;
        o_count    = 2'd0;

        typ     = i_byte[7:6];
        len     = i_byte[5:0];
        too_big = 1'b0;
        n0      = (r_off > 3'd4) ? 3'd4 : r_off;
        mask    = (6'd1 << n0) - 6'd1;
        acc     = {8'h00, r_carry & mask} | ({6'h00, i_byte} << n0);
        want2   = 1'b0;
        c0      = i_byte;
        c1      = i_byte;
        end0    = (r_left == 6'd1);
        end1    = (r_left == 6'd2);
        kind    = KIND_ASCII;

        if (i_step && i_hdr) begin
            if (i_cfg.type3_unicode && typ == ENC_ASCII) begin
                typ = ENC_RAW;
            end
            if (typ == ENC_RAW) begin
                kind = i_cfg.fru_semantics ? KIND_BINARY : KIND_UNICODE;
            end
            // Room check: BCD-plus packs two characters a byte, 6-bit packing
            // fits len characters when 3 * len <= 4 * bytes.
            unique case (t_enc'(typ))
                ENC_BCD: too_big = {3'b000, len} > {i_avail, 1'b0};
                ENC_SIX: too_big = {2'b00, {len, 1'b0} + {2'b00, len}}
                                   > {i_avail, 2'b00};
                default: too_big = {2'b00, len} > i_avail;
            endcase
            if ({1'b0, len} > i_cfg.out_capacity) begin
                too_big = 1'b1;
            end
            n_kind     = kind;
            n_enc      = t_enc'(typ);
            n_off      = 3'd0;
            n_carry    = 6'd0;
            n_in_field = 1'b0;
            n_left     = 6'd0;
            if (too_big || len == 6'd0) begin
                o_res0.decode_error   = too_big;
                o_res0.string_kind    = kind;
                o_res0.last_of_string = 1'b1;
                o_count               = 2'd1;
            end else begin
                n_left     = len;
                n_in_field = 1'b1;
            end
        end else if (i_step && r_in_field) begin
            unique case (r_enc)
                ENC_BCD: begin
                    c0    = bcd_char(i_byte[3:0]);
                    c1    = bcd_char(i_byte[7:4]);
                    want2 = 1'b1;
                end
                ENC_SIX: begin
                    c0    = 8'h20 + {2'b00, acc[5:0]};
                    c1    = 8'h20 + {2'b00, acc[11:6]};
                    want2 = (n0 == 3'd4);
                end
                default: begin
                    c0 = i_byte;
                end
            endcase

            o_res0.char_out       = c0;
            o_res0.char_valid     = 1'b1;
            o_res0.string_kind    = r_kind;
            o_res0.last_of_string = end0;
            o_res1.char_out       = c1;
            o_res1.char_valid     = 1'b1;
            o_res1.string_kind    = r_kind;
            o_res1.last_of_string = end1;

            if (want2 && !end0) begin
                o_count = 2'd2;
                n_left  = r_left - 6'd2;
                n_off   = 3'd0;
                n_carry = {4'h0, acc[13:12]};
                if (end1) begin
                    n_in_field = 1'b0;
                    n_carry    = 6'd0;
                end
            end else begin
                o_count = 2'd1;
                n_left  = r_left - 6'd1;
                n_off   = n0 + 3'd2;
                n_carry = acc[11:6];
                if (end0) begin
                    n_in_field = 1'b0;
                    n_off      = 3'd0;
                    n_carry    = 6'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_field <= 1'b0;
            r_enc      <= ENC_RAW;
            r_left     <= '0;
            r_off      <= '0;
            r_carry    <= '0;
            r_kind     <= KIND_ASCII;
        end else begin
            r_in_field <= n_in_field;
            r_enc      <= n_enc;
            r_left     <= n_left;
            r_off      <= n_off;
            r_carry    <= n_carry;
            r_kind     <= n_kind;
        end
    end

endmodule

// ----- sv/tlsd_result_fifo.sv -----
// Result queue that takes up to two results a cycle and hands out one.
module tlsd_result_fifo
    import tlsd_pkg::*;
#(
    parameter int Depth = RESULT_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_count,
    input  t_result    i_res0,
    input  t_result    i_res1,
    input  logic       i_pop,
    output logic       o_room2,
    output logic       o_valid,
    output t_result    o_head
);

    localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [CntW-1:0] Limit = CntW'(Depth - 2);

    function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] p);
        return (p == IdxW'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    t_result         r_mem [Depth];
    logic [IdxW-1:0] r_wr, n_wr;
    logic [IdxW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_count, n_count;
    logic [IdxW-1:0] wr_next;
    logic            pop;

    assign pop     = i_pop && (r_count != '0);
    assign wr_next = wrap_inc(r_wr);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    // Room for two more results once this cycle's pop is counted.
    assign o_room2 = (r_count - CntW'(pop)) <= Limit;

    always_comb begin
        n_rd    = pop ? wrap_inc(r_rd) : r_rd;
        n_count = r_count + CntW'(i_push_count) - CntW'(pop);
        unique case (i_push_count)
            2'd1:    n_wr = wr_next;
            2'd2:    n_wr = wrap_inc(wr_next);
            default: n_wr = r_wr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[wr_next] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- sv/type_length_string_decoder_unit.sv -----
// Top level of the type/length string decoder: input register, decode and result queue.
//
//   Channel  | Direction | Request carries
//   ---------+-----------+-----------------------------------------------------------
//   s_axis   | in        | tdata {bytes_after, data_byte}, tuser is_header
//   m_axis   | out       | tdata char_out, tuser {decode_error, string_kind, char_valid},
//            |           | tlast last_of_string
//   cfg      | in        | i_cfg_index register index, i_cfg_data value (always ready)
//
// A request is registered, decoded once the result queue has room for two, and its zero,
// one or two results enter the result queue, whose head is the output request.
// One request a cycle while the queue has room for two and each yields at most one result;
// a byte that yields two characters (BCD-plus, or 6-bit with four bits pending) queues both.
// Reset (synchronous, active low) clears input valid, field state and queue, and resets config.
// An output stall holds the queue; the input stalls only when the queue lacks room for two.
module type_length_string_decoder_unit
    import tlsd_pkg::*;
#(
    parameter int ResultDepth = RESULT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [15:8] bytes_after
    input  logic        s_axis_tuser,   // [0] is_header
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] char_out
    output logic [3:0]  m_axis_tuser,   // [0] char_valid, [2:1] string_kind, [3] decode_error
    output logic        m_axis_tlast,   // last_of_string
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    // Configuration registers.
    t_cfg r_cfg;

    // Input register.
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_byte;
    logic              r_in_hdr;
    logic [7:0]        r_in_avail;

    t_result    res0;
    t_result    res1;
    t_result    head;
    logic [1:0] push_count;
    logic       room2;
    logic       step;

    // The registered request is decoded once the queue can absorb its results.
    assign step          = r_in_valid && room2;
    assign s_axis_tready = !r_in_valid || step;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.type3_unicode <= 1'b0;
            r_cfg.fru_semantics <= 1'b0;
            r_cfg.out_capacity  <= CAP_RESET;
        end else if (i_cfg_valid) begin
            // Writes to an index beyond the register list are dropped.
            unique case (i_cfg_index)
                CFG_TYPE3_UNICODE: r_cfg.type3_unicode <= i_cfg_data[0];
                CFG_FRU_SEMANTICS: r_cfg.fru_semantics <= i_cfg_data[0];
                CFG_OUT_CAPACITY:  r_cfg.out_capacity  <= i_cfg_data;
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata[7:0];
            r_in_avail <= s_axis_tdata[15:8];
            r_in_hdr   <= s_axis_tuser;
        end
    end

    tlsd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_hdr   (r_in_hdr),
        .i_avail (r_in_avail),
        .i_cfg   (r_cfg),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_count (push_count)
    );

    tlsd_result_fifo #(
        .Depth (ResultDepth)
    ) u_result_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_res0       (res0),
        .i_res1       (res1),
        .i_pop        (m_axis_tready),
        .o_room2      (room2),
        .o_valid      (m_axis_tvalid),
        .o_head       (head)
    );

    assign m_axis_tdata = head.char_out;
    assign m_axis_tuser = {head.decode_error, head.string_kind, head.char_valid};
    assign m_axis_tlast = head.last_of_string;

endmodule

// ----- tb/tlsd_decode_monitor.sv -----
// Monitor that decodes every input request on its own and checks each result request.
module tlsd_decode_monitor
    import tlsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,
    input  logic [3:0]  i_m_tuser,
    input  logic        i_m_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Register copies, updated on every accepted write.
    logic               type3_unicode;
    logic               fru_binary;
    logic [CAP_W-1:0]   char_limit;

    // State of the field being decoded.
    logic               field_open;
    t_enc               field_enc;
    logic [COUNT_W-1:0] chars_due;
    int                 held_bits;
    logic [5:0]         held_value;
    t_kind              field_kind;

    t_result decoded_chars[$];
    int      fail_count  = 0;
    int      outstanding = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = outstanding;

    function automatic logic [7:0] bcd_glyph(input logic [3:0] code);
        logic [7:0] glyph;
        case (code)
            4'hA:    glyph = " ";
            4'hB:    glyph = "-";
            4'hC:    glyph = ".";
            4'hD:    glyph = ":";
            4'hE:    glyph = ",";
            4'hF:    glyph = "_";
            default: glyph = "0" + {4'h0, code};
        endcase
        return glyph;
    endfunction

    function automatic void queue_result(input logic [7:0] ch, input logic valid,
                                         input logic last, input logic err);
        t_result r;
        r.char_out       = ch;
        r.char_valid     = valid;
        r.last_of_string = last;
        r.string_kind    = field_kind;
        r.decode_error   = err;
        decoded_chars.push_back(r);
    endfunction

    function automatic void emit_char(input logic [7:0] ch);
        chars_due = chars_due - 1'b1;
        queue_result(ch, 1'b1, chars_due == '0, 1'b0);
        if (chars_due == '0) begin
            field_open = 1'b0;
            held_bits  = 0;
            held_value = '0;
        end
    endfunction

    function automatic void decode_request(input logic [7:0] b, input logic hdr,
                                           input logic [7:0] avail);
        t_enc enc;
        int   len;
        int   room;
        int   nbits;
        int   acc;
        if (hdr) begin
            enc = t_enc'(b[7:6]);
            len = int'(b[5:0]);
            if (type3_unicode && enc == ENC_ASCII)
                enc = ENC_RAW;
            if (enc == ENC_RAW)
                field_kind = fru_binary ? KIND_BINARY : KIND_UNICODE;
            else
                field_kind = KIND_ASCII;
            field_enc  = enc;
            field_open = 1'b0;
            chars_due  = '0;
            held_bits  = 0;
            held_value = '0;
            case (enc)
                ENC_BCD: room = 2 * int'(avail);
                ENC_SIX: room = (8 * int'(avail)) / 6;
                default: room = int'(avail);
            endcase
            if (len > room || len > int'(char_limit))
                queue_result('0, 1'b0, 1'b1, 1'b1);
            else if (len == 0)
                queue_result('0, 1'b0, 1'b1, 1'b0);
            else begin
                chars_due  = b[5:0];
                field_open = 1'b1;
            end
        end else if (field_open) begin
            case (field_enc)
                ENC_BCD: begin
                    emit_char(bcd_glyph(b[3:0]));
                    if (field_open)
                        emit_char(bcd_glyph(b[7:4]));
                end
                ENC_SIX: begin
                    // Pending bits sit below the new byte, characters leave LSB first.
                    acc   = (int'(held_value) & ((1 << held_bits) - 1)) | (int'(b) << held_bits);
                    nbits = held_bits + 8;
                    while (nbits >= 6 && field_open) begin
                        emit_char(8'h20 + {2'b00, acc[5:0]});
                        acc   = acc >> 6;
                        nbits = nbits - 6;
                    end
                    if (field_open) begin
                        held_bits  = nbits;
                        held_value = acc[5:0];
                    end
                end
                default: emit_char(b);
            endcase
        end
    endfunction

    function automatic int check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            type3_unicode = 1'b0;
            fru_binary    = 1'b0;
            char_limit    = CAP_RESET;
            field_open    = 1'b0;
            field_enc     = ENC_RAW;
            chars_due     = '0;
            held_bits     = 0;
            held_value    = '0;
            field_kind    = KIND_ASCII;
            decoded_chars.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (decoded_chars.size() == 0) begin
                    $display("%0t: result expected nothing, got char %0h user %0h last %0b",
                             $time, i_m_tdata, i_m_tuser, i_m_tlast);
                    errs++;
                end else begin
                    want = decoded_chars.pop_front();
                    errs += check_field("char_out", want.char_out, i_m_tdata);
                    errs += check_field("char_valid", want.char_valid, i_m_tuser[0]);
                    errs += check_field("string_kind", want.string_kind, i_m_tuser[2:1]);
                    errs += check_field("decode_error", want.decode_error, i_m_tuser[3]);
                    errs += check_field("last_of_string", want.last_of_string, i_m_tlast);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_TYPE3_UNICODE: type3_unicode = i_cfg_data[0];
                    CFG_FRU_SEMANTICS: fru_binary    = i_cfg_data[0];
                    CFG_OUT_CAPACITY:  char_limit    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                decode_request(i_s_tdata[7:0], i_s_tuser, i_s_tdata[15:8]);
        end
        fail_count  <= fail_count + errs;
        outstanding <= decoded_chars.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// Top of the decoder testbench: clock, reset, request stimulus, stalls and the verdict.
module tb_top
    import tlsd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 12;
    // Margin that lets a header that opens a field settle.
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int NUM_PHASES     = 6;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [1:0]  i_cfg_index   = '0;
    logic [6:0]  i_cfg_data    = '0;

    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [7:0]  m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        o_cfg_ready;

    int fail_count;
    int outstanding;

    // Idle percentages of the two sides; the receiver's is read by its own process.
    int   send_idle_pct = 19;
    int   recv_idle_pct = 83;
    logic hold_go       = 1'b0;
    logic hold_rx       = 1'b0;
    int   idle_cycles   = 0;
    int   items_sent    = 0;
    int   cap_now       = CAP_RESET;
    int   phase_items[NUM_PHASES] = '{150, 70, 50, 180, 180, 180};

    type_length_string_decoder_unit uut (.*);

    tlsd_decode_monitor monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .i_m_tlast     (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // The receiver drops ready at random, and holds it low while the long hold-off runs.
    always @(posedge i_clk) begin
        m_axis_tready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
    end

    // One long receiver hold-off: the sender keeps offering, so the result queue fills
    // and the decoder has to stall its input until the hold-off ends.
    initial begin
        wait (hold_go);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    // Any accepted request on any channel restarts the count; a hang ends the run.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("type_length_string_decoder_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one input request after a random gap and waits until it is taken.
    // Valid stays high between back-to-back requests; it only drops during a gap.
    task automatic send_request(input logic [7:0] b, input logic hdr, input logic [7:0] avail);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {avail, b};
        s_axis_tuser  <= hdr;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Stops the input and waits until every predicted result has come out, then lets
    // the pipeline settle, since a header that opens a field produces nothing.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Valid is left high here so that back-to-back writes never lower and raise it
    // within one step; the caller drops it after the last write.
    task automatic write_reg(input t_cfg_index idx, input logic [6:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_settings(input logic force_u, input logic fru, input int cap);
        wait_drained();
        write_reg(CFG_TYPE3_UNICODE, {6'b0, force_u});
        write_reg(CFG_FRU_SEMANTICS, {6'b0, fru});
        write_reg(CFG_OUT_CAPACITY, 7'(cap));
        i_cfg_valid <= 1'b0;
        cap_now = cap;
    endtask

    // A header followed by random content. Mostly the header fits and exactly the
    // bytes it needs follow; sometimes the byte count is short, the field is cut
    // off by the next header, or spare bytes trail after the field has closed.
    task automatic send_random_field();
        t_enc enc;
        int   len;
        int   lim;
        int   need;
        int   avail;
        int   nbytes;
        int   pick;
        enc = t_enc'($urandom_range(3));
        lim = (cap_now > 63) ? 63 : cap_now;
        len = ($urandom_range(99) < 80) ? $urandom_range(lim, 0) : $urandom_range(63);
        case (enc)
            ENC_BCD: need = (len + 1) / 2;
            ENC_SIX: need = (len * 6 + 7) / 8;
            default: need = len;
        endcase
        pick = $urandom_range(99);
        if (pick < 70)
            avail = need + $urandom_range(3);
        else if (pick < 85)
            avail = $urandom_range(255);
        else
            avail = (need > 0) ? need - 1 : 0;
        send_request({enc, 6'(len)}, 1'b1, 8'(avail));
        pick = $urandom_range(99);
        if (pick < 80)
            nbytes = need;
        else if (pick < 90)
            nbytes = $urandom_range(need);
        else
            nbytes = need + $urandom_range(3, 1);
        repeat (nbytes) send_request(8'($urandom), 1'b0, 8'($urandom));
    endtask

    initial begin
        int start;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests with the registers at their reset values.
        // An empty field, then a full-length header with no bytes behind it.
        send_request({ENC_ASCII, 6'd0}, 1'b1, 8'd0);
        send_request({ENC_ASCII, 6'd63}, 1'b1, 8'd0);
        // Raw unicode, all-zero and all-one bytes.
        send_request({ENC_RAW, 6'd2}, 1'b1, 8'd255);
        send_request(8'h00, 1'b0, 8'h00);
        send_request(8'hFF, 1'b0, 8'hFF);
        // BCD-plus punctuation codes, then every digit.
        send_request({ENC_BCD, 6'd6}, 1'b1, 8'd3);
        send_request(8'hBA, 1'b0, 8'd0);
        send_request(8'hDC, 1'b0, 8'd0);
        send_request(8'hFE, 1'b0, 8'd0);
        send_request({ENC_BCD, 6'd10}, 1'b1, 8'd5);
        send_request(8'h10, 1'b0, 8'd0);
        send_request(8'h32, 1'b0, 8'd0);
        send_request(8'h54, 1'b0, 8'd0);
        send_request(8'h76, 1'b0, 8'd0);
        send_request(8'h98, 1'b0, 8'd0);
        // 6-bit packing: the first code maps to '@' and the bits left over after the
        // third character are dropped.
        send_request({ENC_SIX, 6'd3}, 1'b1, 8'd3);
        send_request(8'h20, 1'b0, 8'd0);
        send_request(8'h00, 1'b0, 8'd0);
        send_request(8'hFF, 1'b0, 8'd0);
        // Five 6-bit characters cannot fit in three bytes.
        send_request({ENC_SIX, 6'd5}, 1'b1, 8'd3);
        // A data byte with no field open is ignored.
        send_request(8'h55, 1'b0, 8'd7);
        // A new header abandons a field halfway through.
        send_request({ENC_ASCII, 6'd3}, 1'b1, 8'd3);
        send_request(8'h41, 1'b0, 8'd0);
        send_request({ENC_ASCII, 6'd1}, 1'b1, 8'd1);
        send_request(8'h7E, 1'b0, 8'd0);

        // Random phases, each under its own register setting. The receiver idles most
        // in the first two, the sender in the next two, nobody in the last two.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 2) begin
                send_idle_pct = 83;
                recv_idle_pct <= 19;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            case (p)
                0:       apply_settings(1'b0, 1'b0, 64);
                1:       apply_settings(1'b1, 1'b1, 1);
                2:       apply_settings(1'b1, 1'b0, 0);
                3:       apply_settings(1'b0, 1'b1, 64);
                4:       apply_settings(1'b1, 1'b1, $urandom_range(63, 2));
                default: apply_settings(1'b0, 1'b0, $urandom_range(64, 1));
            endcase
            start = items_sent;
            while (items_sent - start < phase_items[p]) begin
                if (p == 4 && !hold_go && items_sent - start >= 20)
                    hold_go <= 1'b1;
                // A few stray requests of either kind with random content.
                if ($urandom_range(99) < 6)
                    send_request(8'($urandom), 1'($urandom_range(1)), 8'($urandom));
                else
                    send_random_field();
            end
        end

        wait_drained();
        if (fail_count == 0 && outstanding == 0)
            $display("type_length_string_decoder_unit: match");
        else
            $display("type_length_string_decoder_unit: mismatch");
        $finish;
    end

endmodule
